// ===== hdl/pkmer_pkg.sv =====
// Shared types, widths, register codes and log lookup tables for the Poisson k-mer
// profile scorer. No dependencies; every other file of the block imports this package.
package pkmer_pkg;

  localparam int COUNT_BITS = 10;
  localparam int COUNT_SIZE = 1 << COUNT_BITS;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 48;
  localparam int LOG_W      = 21;
  localparam int LFACT_W    = COUNT_BITS + 21;
  localparam int LR_W       = 33;
  localparam int RATE_W     = COUNT_BITS + 32;
  localparam int PROD_W     = COUNT_BITS + 34;
  localparam int TERM_W     = COUNT_BITS + 35;
  localparam int SUM_W      = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
  localparam int QDEPTH     = 8;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int OB_DEPTH   = 2;
  localparam int OB_PTR_W   = $clog2(OB_DEPTH);
  localparam int OB_CNT_W   = $clog2(OB_DEPTH + 1);

  localparam logic [63:0] LN2_Q31 = 64'd1488522236;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_RATE_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_RATE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_ERROR_RATE = 2'd3;

  localparam logic [CFG_W-1:0] RATE_SCALE_RESET = 32'd65536;
  localparam logic [CFG_W-1:0] ERROR_RATE_RESET = 32'd65536;

  typedef struct packed {
    logic [COUNT_BITS-1:0] reads_count;
    logic [COUNT_BITS-1:0] profile_count;
    logic                  last_kmer;
  } kmer_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] profile_score;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0]        rate_scale;
    logic signed [CFG_W-1:0] log_rate_scale;
    logic [CFG_W-1:0]        error_rate;
    logic signed [CFG_W-1:0] log_error_rate;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     last_kmer;
  } term_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              valid;
  } queue_status_t;

  typedef logic [LOG_W-1:0]   log_table_t   [COUNT_SIZE];
  typedef logic [LFACT_W-1:0] lfact_table_t [COUNT_SIZE];

  // ln(n) in Q16.16 through a bit-by-bit log2 of the normalized mantissa.
  function automatic logic [LOG_W-1:0] ln_q16(input int unsigned n);
    int unsigned e;
    int unsigned t;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] l2;
    logic [63:0] p;
    e    = 0;
    t    = n;
    frac = 64'd0;
    while (t > 1) begin
      t = t >> 1;
      e = e + 1;
    end
    m = 64'(n) << (31 - e);
    for (int i = 0; i < 28; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    l2 = (64'(e) << 28) | frac;
    p  = l2 * LN2_Q31;
    return LOG_W'((p + (64'd1 << 42)) >> 43);
  endfunction

  function automatic log_table_t build_log_table();
    log_table_t tbl;
    tbl[0] = '0;
    for (int n = 1; n < COUNT_SIZE; n++) begin
      tbl[n] = ln_q16(n);
    end
    return tbl;
  endfunction

  function automatic lfact_table_t build_lfact_table();
    lfact_table_t tbl;
    logic [LFACT_W-1:0] acc;
    acc    = '0;
    tbl[0] = '0;
    for (int n = 1; n < COUNT_SIZE; n++) begin
      acc    = acc + LFACT_W'(ln_q16(n));
      tbl[n] = acc;
    end
    return tbl;
  endfunction

  localparam log_table_t   LOG_TABLE   = build_log_table();
  localparam lfact_table_t LFACT_TABLE = build_lfact_table();

endpackage

// ===== hdl/pkmer_front.sv =====
// Front end: accepts k-mer items, classifies them by profile count and forms each
// item's log Poisson term over three stages. Depends on pkmer_pkg.
module pkmer_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pkmer_pkg::kmer_t      kmer,
  input  pkmer_pkg::cfg_regs_t  cfg,
  input  pkmer_pkg::queue_status_t q_status,
  output logic                  full,
  output logic                  q_push,
  output pkmer_pkg::term_item_t q_item
);
  import pkmer_pkg::*;

  logic [QCNT_W:0] in_flight;
  logic            accept;

  logic v1;
  logic v2;
  logic v3;

  // Stage 1: captured counts and registered table reads.
  logic [COUNT_BITS-1:0] c1;
  logic [COUNT_BITS-1:0] a1;
  logic                  zero1;
  logic                  last1;
  logic [LOG_W-1:0]      logv1;
  logic [LFACT_W-1:0]    lf1;

  // Stage 2: log rate and rate.
  logic [COUNT_BITS-1:0]  c2;
  logic                   last2;
  logic [LFACT_W-1:0]     lf2;
  logic signed [LR_W-1:0] lr2;
  logic [RATE_W-1:0]      rate2;

  // Stage 3: count times log rate.
  logic                     last3;
  logic [LFACT_W-1:0]       lf3;
  logic [RATE_W-1:0]        rate3;
  logic signed [PROD_W-1:0] prod3;

  logic signed [LR_W-1:0]   lr_next;
  logic [RATE_W-1:0]        rate_next;
  logic signed [PROD_W-1:0] prod_next;

  // Items in the pipe plus items queued never exceed the queue depth.
  assign in_flight = {1'b0, q_status.level} + (QCNT_W + 1)'(v1) + (QCNT_W + 1)'(v2)
                   + (QCNT_W + 1)'(v3);
  assign full      = in_flight >= (QCNT_W + 1)'(QDEPTH);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    if (zero1) begin
      lr_next   = {cfg.log_error_rate[CFG_W-1], cfg.log_error_rate};
      rate_next = RATE_W'(cfg.error_rate);
    end else begin
      lr_next   = {cfg.log_rate_scale[CFG_W-1], cfg.log_rate_scale}
                + $signed({{(LR_W - LOG_W){1'b0}}, logv1});
      rate_next = RATE_W'(cfg.rate_scale) * RATE_W'(a1);
    end
    prod_next = $signed({1'b0, c2}) * lr2;
  end

  always_ff @(posedge clk) begin
    c1    <= kmer.reads_count;
    a1    <= kmer.profile_count;
    zero1 <= kmer.profile_count == '0;
    last1 <= kmer.last_kmer;
    logv1 <= LOG_TABLE[kmer.profile_count];
    lf1   <= LFACT_TABLE[kmer.reads_count];

    c2    <= c1;
    last2 <= last1;
    lf2   <= lf1;
    lr2   <= lr_next;
    rate2 <= rate_next;

    last3 <= last2;
    lf3   <= lf2;
    rate3 <= rate2;
    prod3 <= prod_next;
  end

  assign q_push           = v3;
  assign q_item.last_kmer = last3;
  assign q_item.term      = {prod3[PROD_W-1], prod3}
                          - $signed({{(TERM_W - RATE_W){1'b0}}, rate3})
                          - $signed({{(TERM_W - LFACT_W){1'b0}}, lf3});

endmodule

// ===== hdl/pkmer_queue.sv =====
// Short queue of per-item terms between the front and back ends.
// Depends on pkmer_pkg.
module pkmer_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  pkmer_pkg::term_item_t     wr_item,
  input  logic                      rd,
  output pkmer_pkg::term_item_t     head,
  output pkmer_pkg::queue_status_t  status
);
  import pkmer_pkg::*;

  term_item_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.level = level;
  assign status.valid = level != '0;

endmodule

// ===== hdl/pkmer_back.sv =====
// Back end: saturating 48-bit accumulation of item terms and a two-entry result
// buffer toward the consumer. Depends on pkmer_pkg.
module pkmer_back (
  input  logic                     clk,
  input  logic                     rst,
  input  pkmer_pkg::term_item_t    q_head,
  input  pkmer_pkg::queue_status_t q_status,
  output logic                     q_pop,
  input  logic                     pop,
  output logic                     empty,
  output pkmer_pkg::result_t       result
);
  import pkmer_pkg::*;

  logic signed [ACC_W-1:0] score_sum;
  logic                    clip_seen;

  logic signed [SUM_W-1:0] sum_wide;
  logic [SUM_W-ACC_W:0]    sum_top;
  logic                    clip_now;
  logic signed [ACC_W-1:0] sum_sat;

  result_t               ob [OB_DEPTH];
  logic [OB_PTR_W-1:0]   ob_wr;
  logic [OB_PTR_W-1:0]   ob_rd;
  logic [OB_CNT_W-1:0]   ob_count;
  logic                  ob_push;
  logic                  ob_pop;

  assign q_pop = q_status.valid && (!q_head.last_kmer || ob_count != OB_CNT_W'(OB_DEPTH));

  always_comb begin
    sum_wide = {{(SUM_W - ACC_W){score_sum[ACC_W-1]}}, score_sum}
             + {{(SUM_W - TERM_W){q_head.term[TERM_W-1]}}, q_head.term};
    sum_top  = sum_wide[SUM_W-1:ACC_W-1];
    // Out of range when the accumulator's sign bit and the bits above it disagree.
    clip_now = !((&sum_top) || !(|sum_top));
    if (!clip_now) begin
      sum_sat = sum_wide[ACC_W-1:0];
    end else if (sum_wide[SUM_W-1]) begin
      sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
    end
  end

  assign ob_push = q_pop && q_head.last_kmer;
  assign ob_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_sum <= '0;
      clip_seen <= 1'b0;
      ob_wr     <= '0;
      ob_rd     <= '0;
      ob_count  <= '0;
    end else begin
      if (q_pop) begin
        if (q_head.last_kmer) begin
          score_sum <= '0;
          clip_seen <= 1'b0;
        end else begin
          score_sum <= sum_sat;
          clip_seen <= clip_seen || clip_now;
        end
      end
      if (ob_push) begin
        ob_wr <= ob_wr + OB_PTR_W'(1);
      end
      if (ob_pop) begin
        ob_rd <= ob_rd + OB_PTR_W'(1);
      end
      ob_count <= ob_count + OB_CNT_W'(ob_push) - OB_CNT_W'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob[ob_wr].profile_score <= sum_sat;
      ob[ob_wr].saturated     <= clip_seen || clip_now;
    end
  end

  assign empty  = ob_count == '0;
  assign result = ob[ob_rd];

endmodule

// ===== hdl/poisson_kmer_profile_scorer_core.sv =====
// Top level of the Poisson k-mer profile scorer: configuration registers, front end,
// term queue and back end. Depends on pkmer_pkg, pkmer_front, pkmer_queue, pkmer_back.
//
//   Channel   Handshake          Payload                         Direction
//   -------   ----------------   -----------------------------   ---------
//   kmer      push / full        reads_count, profile_count,     in
//                                last_kmer
//   result    empty / pop        profile_score, saturated        out
//   config    cfg_write          cfg_index, cfg_data             in
//
// One item is taken per clock cycle when the term queue has room; the front end is
// a three-stage pipeline (table reads, rate multiply, count multiply) feeding an
// eight-entry queue, and the back end adds one term per cycle into the accumulator
// while the queue holds one, unless a last item waits on a full result buffer.
// Reset is synchronous; it empties both queues and clears the accumulator and the
// clip flag, and the configuration registers return to rate 1.0 and log 0.
// When the consumer stops popping, the two-entry result buffer fills, the back end
// holds the last item at the head of the queue, and full rises once the queue and
// the items still in the pipeline reach eight.
module poisson_kmer_profile_scorer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  pkmer_pkg::kmer_t                    kmer,
  output logic                                empty,
  input  logic                                pop,
  output pkmer_pkg::result_t                  result,
  input  logic                                cfg_write,
  input  logic [pkmer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pkmer_pkg::CFG_W-1:0]         cfg_data
);
  import pkmer_pkg::*;

  cfg_regs_t     cfg;
  logic          q_push;
  term_item_t    q_item;
  logic          q_pop;
  term_item_t    q_head;
  queue_status_t q_status;

  // Software must write these only while the block is idle; the block itself does not
  // enforce this, and the pipeline reads them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_scale     <= RATE_SCALE_RESET;
      cfg.log_rate_scale <= '0;
      cfg.error_rate     <= ERROR_RATE_RESET;
      cfg.log_error_rate <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RATE_SCALE:     cfg.rate_scale     <= cfg_data;
        REG_LOG_RATE_SCALE: cfg.log_rate_scale <= cfg_data;
        REG_ERROR_RATE:     cfg.error_rate     <= cfg_data;
        REG_LOG_ERROR_RATE: cfg.log_error_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: accepts items and turns each one into a signed Q16.16 term.
  pkmer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .kmer     (kmer),
    .cfg      (cfg),
    .q_status (q_status),
    .full     (full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // The queue decouples the front pipeline from a stalled back end.
  pkmer_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_item),
    .rd      (q_pop),
    .head    (q_head),
    .status  (q_status)
  );

  // Back end: saturating accumulation and the result buffer.
  pkmer_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// ===== hdl/pkmer_checker.sv =====
// Port-level checks for the Poisson k-mer profile scorer, bound to the top level.
// Depends on pkmer_pkg and poisson_kmer_profile_scorer_core.
module pkmer_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input pkmer_pkg::result_t              result
);
  import pkmer_pkg::*;

  // Reset leaves no result waiting and room for new items.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result pending or full set after reset");

  // The queue only fills up through accepted items.
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

  // A waiting result is neither dropped nor changed until popped.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result lost or changed");

endmodule

bind poisson_kmer_profile_scorer_core pkmer_checker u_checker (.*);

// ===== verif/poisson_kmer_profile_scorer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for poisson_kmer_profile_scorer_core: streams k-mer count pairs
// under several register settings and checks every profile score. Depends on pkmer_pkg.
module poisson_kmer_profile_scorer_core_tb;
  import pkmer_pkg::*;

  // A correct run never goes this long without moving an item in either direction.
  // The longest quiet stretch is the drain pause plus the register writes after it.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let the pipeline and the term queue empty out after the last score.
  // Terms pass through the front stages into the term queue, which holds up to eight.
  localparam int DRAIN_CYCLES = 24;
  // Rough number of k-mers sent under each register setting in the random part.
  localparam int ITEMS_PER_SETTING = 60;

  localparam longint SCORE_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SCORE_MIN = -SCORE_MAX - 1;

  // Register settings the random part cycles through.
  typedef enum int {
    SET_RESET_VALUES,
    SET_TYPICAL,
    SET_RATE_MAX,
    SET_RATE_MIN,
    SET_RATE_ZERO,
    SET_RANDOM,
    SET_COUNT
  } setting_e;

  // Tracks the running log likelihood of the profile being scored and holds the
  // scores that the block still owes us, oldest first.
  class likelihood_tracker;
    int unsigned ln_q[COUNT_SIZE];
    longint      ln_fact_q[COUNT_SIZE];
    cfg_regs_t   regs;
    longint      score_acc;
    bit          clipped;
    result_t     scores_due[$];
    int          mismatches;
    int          kmers_seen;
    int          profiles_seen;
    int          profiles_clipped;

    function new();
      longint run;
      run          = 0;
      ln_q[0]      = 0;
      ln_fact_q[0] = 0;
      for (int n = 1; n < COUNT_SIZE; n++) begin
        ln_q[n]      = fixed_ln(n);
        run          = run + longint'(ln_q[n]);
        ln_fact_q[n] = run;
      end
      regs.rate_scale     = RATE_SCALE_RESET;
      regs.log_rate_scale = '0;
      regs.error_rate     = ERROR_RATE_RESET;
      regs.log_error_rate = '0;
      score_acc        = 0;
      clipped          = 1'b0;
      mismatches       = 0;
      kmers_seen       = 0;
      profiles_seen    = 0;
      profiles_clipped = 0;
    endfunction

    // ln(n) in Q16.16: normalize n to a Q31 mantissa in [1,2), extract 28 fraction
    // bits of log2 by repeated squaring, then scale by ln 2 with rounding.
    function int unsigned fixed_ln(int unsigned n);
      int unsigned expo;
      bit [63:0]   mant;
      bit [63:0]   log2_q28;
      bit [63:0]   prod;
      expo = 0;
      while ((n >> (expo + 1)) != 0) expo++;
      mant     = 64'(n) << (31 - expo);
      log2_q28 = 64'(expo) << 28;
      for (int i = 27; i >= 0; i--) begin
        mant = (mant * mant) >> 31;
        if (mant[32]) begin
          log2_q28[i] = 1'b1;
          mant        = mant >> 1;
        end
      end
      prod = log2_q28 * LN2_Q31;
      return 32'((prod + (64'd1 << 42)) >> 43);
    endfunction

    function void set_regs(cfg_regs_t v);
      regs = v;
    endfunction

    // Adds one accepted k-mer to the running score; a last k-mer closes the profile
    // and queues the score the block must produce.
    function void take_kmer(kmer_t k);
      longint  reads;
      longint  copies;
      longint  rate;
      longint  log_rate;
      longint  term;
      longint  total;
      result_t due;
      reads  = longint'(k.reads_count);
      copies = longint'(k.profile_count);
      if (copies == 0) begin
        rate     = longint'($unsigned(regs.error_rate));
        log_rate = longint'($signed(regs.log_error_rate));
      end else begin
        rate     = longint'($unsigned(regs.rate_scale)) * copies;
        log_rate = longint'($signed(regs.log_rate_scale)) + longint'(ln_q[copies]);
      end
      term  = reads * log_rate - rate - ln_fact_q[reads];
      total = score_acc + term;
      if (total > SCORE_MAX) begin
        total   = SCORE_MAX;
        clipped = 1'b1;
      end else if (total < SCORE_MIN) begin
        total   = SCORE_MIN;
        clipped = 1'b1;
      end
      score_acc = total;
      kmers_seen++;
      if (k.last_kmer) begin
        due.profile_score = total[ACC_W-1:0];
        due.saturated     = clipped;
        scores_due        = {scores_due, due};
        profiles_seen++;
        if (clipped) profiles_clipped++;
        score_acc = 0;
        clipped   = 1'b0;
      end
    endfunction

    function void check_score(result_t got);
      result_t want;
      if (scores_due.size() == 0) begin
        $error("score with no profile pending: profile_score %0d saturated %0d",
               $signed(got.profile_score), got.saturated);
        mismatches++;
        return;
      end
      want = scores_due.pop_front();
      if (got.profile_score !== want.profile_score) begin
        $error("profile_score: expected %0d, got %0d",
               $signed(want.profile_score), $signed(got.profile_score));
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  kmer_t                kmer;
  logic                 empty;
  logic                 pop;
  result_t              result;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  likelihood_tracker tracker;
  int                send_idle_pct;
  int                take_idle_pct;
  int                quiet_cycles;
  int                settings_run;

  poisson_kmer_profile_scorer_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kmer      (kmer),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Result side. Every process samples right after the rising edge, so it sees the
  // values the block itself used at that edge. A score is taken when pop was high
  // and empty low; pop for the next edge is then drawn at the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.check_score(result);
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Watchdog: count cycles in which no item moves on either side. Reset and the
  // drain pauses are short, so hitting the limit means the block has hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic kmer_t make_kmer(int unsigned reads, int unsigned copies, bit last);
    kmer_t k;
    k.reads_count   = COUNT_BITS'(reads);
    k.profile_count = COUNT_BITS'(copies);
    k.last_kmer     = last;
    return k;
  endfunction

  // Counts lean on the edges: zero, full scale and small values show up often,
  // with the whole range filling in the rest.
  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 0;
    if (sel == 1) return COUNT_SIZE - 1;
    if (sel <= 5) return $urandom_range(15);
    return $urandom_range(COUNT_SIZE - 1);
  endfunction

  function automatic cfg_regs_t pick_regs(setting_e kind);
    cfg_regs_t v;
    case (kind)
      SET_RESET_VALUES: begin
        v.rate_scale     = RATE_SCALE_RESET;
        v.log_rate_scale = '0;
        v.error_rate     = ERROR_RATE_RESET;
        v.log_error_rate = '0;
      end
      SET_TYPICAL: begin
        // Plausible coverage: half to forty reads per copy, an error rate up to 1.0.
        v.rate_scale     = $urandom_range(32'h0028_0000, 32'h0000_8000);
        v.log_rate_scale = $urandom_range(250000);
        v.error_rate     = $urandom_range(32'h0001_0000, 1);
        v.log_error_rate = -int'($urandom_range(800000));
      end
      SET_RATE_MAX: begin
        v.rate_scale     = '1;
        v.log_rate_scale = 32'h7FFF_FFFF;
        v.error_rate     = '1;
        v.log_error_rate = 32'h7FFF_FFFF;
      end
      SET_RATE_MIN: begin
        v.rate_scale     = 32'd1;
        v.log_rate_scale = 32'h8000_0000;
        v.error_rate     = 32'd1;
        v.log_error_rate = 32'h8000_0000;
      end
      SET_RATE_ZERO: begin
        // A zero rate is used as is, whatever the log registers hold.
        v.rate_scale     = '0;
        v.log_rate_scale = $urandom;
        v.error_rate     = '0;
        v.log_error_rate = $urandom;
      end
      default: begin
        v.rate_scale     = $urandom;
        v.log_rate_scale = $urandom;
        v.error_rate     = $urandom;
        v.log_error_rate = $urandom;
      end
    endcase
    return v;
  endfunction

  // Offers one k-mer and returns once the block has taken it. Push stays high
  // afterwards so back-to-back k-mers need no gap; the caller lowers it when done.
  task automatic send_kmer(input kmer_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kmer <= k;
    do @(posedge clk); while (full);
    tracker.take_kmer(k);
  endtask

  // One union set. A heavy profile uses near full-scale read counts, mostly with
  // k-mers absent from the allele, so extreme settings drive the sum into a clip.
  task automatic send_profile(input int len, input bit heavy);
    int unsigned reads;
    int unsigned copies;
    for (int i = 0; i < len; i++) begin
      if (heavy) begin
        reads  = COUNT_SIZE - 1 - $urandom_range(63);
        copies = ($urandom_range(7) != 0) ? 0 : pick_count();
      end else begin
        reads  = pick_count();
        copies = pick_count();
      end
      send_kmer(make_kmer(reads, copies, i == len - 1));
    end
  endtask

  // Waits until every owed score has come back, then lets the pipeline run dry.
  task automatic wait_idle();
    push <= 1'b0;
    while (tracker.scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges; the block must be idle.
  task automatic load_regs(input cfg_regs_t v);
    cfg_write <= 1'b1;
    cfg_index <= REG_RATE_SCALE;
    cfg_data  <= v.rate_scale;
    @(posedge clk);
    cfg_index <= REG_LOG_RATE_SCALE;
    cfg_data  <= v.log_rate_scale;
    @(posedge clk);
    cfg_index <= REG_ERROR_RATE;
    cfg_data  <= v.error_rate;
    @(posedge clk);
    cfg_index <= REG_LOG_ERROR_RATE;
    cfg_data  <= v.log_error_rate;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_regs(v);
    settings_run++;
  endtask

  initial begin
    setting_e    kind;
    int          sent;
    int          len;
    bit          heavy;
    cfg_regs_t   zero_regs;
    tracker       = new();
    send_idle_pct = 25;
    take_idle_pct = 56;
    settings_run  = 0;
    rst       <= 1'b1;
    push      <= 1'b0;
    kmer      <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_RATE_SCALE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset values: single-k-mer profiles at the corners
    // of both counts, then one longer profile with mixed counts.
    send_kmer(make_kmer(0, 0, 1'b1));
    send_kmer(make_kmer(COUNT_SIZE - 1, COUNT_SIZE - 1, 1'b1));
    send_kmer(make_kmer(COUNT_SIZE - 1, 0, 1'b1));
    send_kmer(make_kmer(0, COUNT_SIZE - 1, 1'b1));
    send_kmer(make_kmer(1, 1, 1'b0));
    send_kmer(make_kmer(2, 1, 1'b0));
    send_kmer(make_kmer(1, 2, 1'b0));
    send_kmer(make_kmer(COUNT_SIZE / 2, COUNT_SIZE / 2, 1'b0));
    send_kmer(make_kmer(COUNT_SIZE / 2 - 1, 0, 1'b0));
    send_kmer(make_kmer(COUNT_SIZE - 1, 1, 1'b1));

    // Zero rates with nonzero logs: only the count times log and factorial terms
    // remain, for present and absent k-mers alike.
    wait_idle();
    zero_regs.rate_scale     = '0;
    zero_regs.log_rate_scale = 32'h0001_0000;
    zero_regs.error_rate     = '0;
    zero_regs.log_error_rate = 32'hFFFF_0000;
    load_regs(zero_regs);
    send_kmer(make_kmer(5, 0, 1'b1));
    send_kmer(make_kmer(5, 3, 1'b1));
    send_kmer(make_kmer(0, 0, 1'b0));
    send_kmer(make_kmer(COUNT_SIZE - 1, COUNT_SIZE - 1, 1'b1));

    // Random part: three idling regimes, each walking through every register
    // setting. Under the extreme settings the first profile is heavy so the
    // accumulator clips high or low, and the next profile checks the flag cleared.
    for (int regime = 0; regime < 3; regime++) begin
      for (int s = 0; s < int'(SET_COUNT); s++) begin
        kind = setting_e'(s);
        wait_idle();
        case (regime)
          0: begin
            send_idle_pct = 25;
            take_idle_pct = 56;
          end
          1: begin
            send_idle_pct = 56;
            take_idle_pct = 25;
          end
          default: begin
            send_idle_pct = 0;
            take_idle_pct = 0;
          end
        endcase
        load_regs(pick_regs(kind));
        sent  = 0;
        heavy = (kind == SET_RATE_MAX) || (kind == SET_RATE_MIN);
        while (sent < ITEMS_PER_SETTING) begin
          if (heavy) begin
            len = $urandom_range(120, 80);
          end else if ($urandom_range(4) == 0) begin
            len = $urandom_range(30, 10);
          end else begin
            len = $urandom_range(8, 1);
          end
          send_profile(len, heavy);
          sent  = sent + len;
          heavy = 1'b0;
        end
      end
    end

    wait_idle();
    $display("Scored %0d k-mers in %0d profiles, %0d of them clipped, over %0d settings.",
             tracker.kmers_seen, tracker.profiles_seen, tracker.profiles_clipped,
             settings_run);
    $display("Idling ran sender-heavy, receiver-heavy and then back to back.");
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pkmer_pkg.sv
hdl/pkmer_front.sv
hdl/pkmer_queue.sv
hdl/pkmer_back.sv
hdl/poisson_kmer_profile_scorer_core.sv
hdl/pkmer_checker.sv
verif/poisson_kmer_profile_scorer_core_tb.sv
